@@ design/s2a_pkg.sv @@
package s2a_pkg;

    // Item and character types.
    typedef logic [6:0] t_char;
    typedef logic [7:0] t_code;

    // Operation codes carried on the operation field.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Set-1 scancodes with a special meaning.
    localparam t_code SC_LSHIFT_DOWN = 8'h2A;
    localparam t_code SC_RSHIFT_DOWN = 8'h36;
    localparam t_code SC_LSHIFT_UP   = 8'hAA;
    localparam t_code SC_RSHIFT_UP   = 8'hB6;
    localparam t_code SC_CAPS        = 8'h3A;
    localparam t_code SC_BREAK_BIT   = 8'h80;

    // Number of make codes covered by the key maps.
    localparam int unsigned KEYMAP_LEN = 59;

    // ASCII letter bounds used for the caps lock case swap.
    localparam t_char CH_LOWER_A = 7'h61;
    localparam t_char CH_LOWER_Z = 7'h7A;
    localparam t_char CH_UPPER_A = 7'h41;
    localparam t_char CH_UPPER_Z = 7'h5A;

    // US layout without shift.
    localparam t_char PLAIN_MAP [KEYMAP_LEN] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    // US layout with shift held.
    localparam t_char SHIFTED_MAP [KEYMAP_LEN] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    // Translate a make code into a character; 0 means no character.
    function automatic t_char translate(t_code code, logic shift, logic caps);
        t_char ch;
        ch = '0;
        if (code < t_code'(KEYMAP_LEN)) begin
            ch = shift ? SHIFTED_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
        end
        // Caps lock swaps the case of letters only.
        if (caps && (((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z)) ||
                     ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)))) begin
            ch[5] = ~ch[5];
        end
        return ch;
    endfunction

endpackage

@@ design/scancode_to_ascii_fifo_top.sv @@
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle unless the output stalls; each item makes one
// pass through the translation table and at most one character memory access.
// Reset (synchronous, active low) empties the FIFO and clears shift and caps
// lock; the character memory itself is not cleared and needs no clearing pass.
module scancode_to_ascii_fifo_top
    import s2a_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_operation,
    input  logic [7:0] i_scancode,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_read_char,
    output logic       o_read_valid,
    output logic       o_key_available,
    output logic       o_dropped
);

    localparam int unsigned AW = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);

    // Input register.
    logic  r_in_valid;
    logic  r_op;
    t_code r_code;

    // Translator and FIFO state.
    logic          r_shift;
    logic          r_caps;
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    t_char         r_store [FIFO_DEPTH];

    // Result register.
    logic  r_out_valid;
    t_char r_rd_char;
    logic  r_rd_valid;
    logic  r_avail;
    logic  r_dropped;

    // Next values.
    logic          n_shift;
    logic          n_caps;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic          n_dropped;
    logic          n_rd_valid;
    logic          do_write;
    t_char         ch;
    logic [AW-1:0] wr_next;
    logic [AW-1:0] rd_next;
    logic          out_free;
    logic          advance;

    // Handshake: the working stage moves on when the result register is free.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Input transfers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op   <= i_operation;
            r_code <= i_scancode;
        end
    end

    // Ring pointer increments with wrap at the last slot.
    assign wr_next = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
    assign rd_next = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
    assign ch      = translate(r_code, r_shift, r_caps);

    // Scancode decode and FIFO update for the item in the working stage.
    always_comb begin
        n_shift    = r_shift;
        n_caps     = r_caps;
        n_wr_ptr   = r_wr_ptr;
        n_rd_ptr   = r_rd_ptr;
        n_dropped  = 1'b0;
        n_rd_valid = 1'b0;
        do_write   = 1'b0;
        if (r_op == OP_PUSH) begin
            unique case (r_code)
                SC_LSHIFT_DOWN, SC_RSHIFT_DOWN: begin
                    n_shift = 1'b1;
                end
                SC_LSHIFT_UP, SC_RSHIFT_UP: begin
                    n_shift = 1'b0;
                end
                SC_CAPS: begin
                    n_caps = ~r_caps;
                end
                default: begin
                    // Release codes are ignored; make codes may yield a character.
                    if (((r_code & SC_BREAK_BIT) == '0) && (ch != '0)) begin
                        if (wr_next != r_rd_ptr) begin
                            do_write = 1'b1;
                            n_wr_ptr = wr_next;
                        end else begin
                            n_dropped = 1'b1;
                        end
                    end
                end
            endcase
        end else if (r_rd_ptr != r_wr_ptr) begin
            n_rd_valid = 1'b1;
            n_rd_ptr   = rd_next;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_caps   <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else if (advance) begin
            r_shift  <= n_shift;
            r_caps   <= n_caps;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // Character memory; the read data lands in the result register.
    always_ff @(posedge i_clk) begin
        if (advance && do_write) begin
            r_store[r_wr_ptr] <= ch;
        end
        if (advance && n_rd_valid) begin
            r_rd_char <= r_store[r_rd_ptr];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rd_valid <= n_rd_valid;
            r_avail    <= (n_wr_ptr != n_rd_ptr);
            r_dropped  <= n_dropped;
        end
    end

    // Output fields; the character reads as zero when nothing was popped.
    assign o_out_valid     = r_out_valid;
    assign o_read_char     = r_rd_valid ? r_rd_char : '0;
    assign o_read_valid    = r_rd_valid;
    assign o_key_available = r_avail;
    assign o_dropped       = r_dropped;

endmodule
